// File: rtl/desa_pkg.sv
// Package for the double-ended stack allocator: widths, codes and helper functions.
// Used by the head cells, the head-cell chain and the top level.
package desa_pkg;

  localparam int unsigned AddrW          = 32;
  localparam int unsigned ActW           = 3;
  localparam int unsigned StatW          = 3;
  localparam int unsigned DefSideDepth   = 64;
  localparam int unsigned DefSnapDepth   = 16;
  localparam int unsigned DefSnapBytes   = 32;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned HdrBytes       = 16;

  typedef enum logic [ActW-1:0] {
    ActAlloc   = 3'd0,
    ActFree    = 3'd1,
    ActRealloc = 3'd2,
    ActPush    = 3'd3,
    ActPop     = 3'd4
  } action_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 3'd0,
    StNoSpace  = 3'd1,
    StNotNewest = 3'd2,
    StFull     = 3'd3,
    StNoSnap   = 3'd4,
    StUnknown  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPoolStart = 1'b0,
    RegPoolEnd   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [AddrW-1:0] req_size;
    logic             side;
    logic [AddrW-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_addr;
    logic [StatW-1:0] status;
    logic [AddrW-1:0] free_bytes;
  } rsp_t;

  // Cost of a block in 33 bits: align16(size) + 16, never wraps.
  function automatic logic [AddrW:0] cost_of(input logic [AddrW-1:0] size);
    logic [AddrW:0] s;
    s = {1'b0, size} + (AddrW+1)'(15);
    s[3:0] = 4'd0;
    return s + (AddrW+1)'(HdrBytes);
  endfunction

endpackage

// File: rtl/desa_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing but its type parameter.
interface desa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/desa_cell.sv
// One cell of a head chain: holds one stack entry and takes its neighbor's entry on a shift.
// Depends on desa_pkg.
module desa_cell (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [desa_pkg::AddrW-1:0]  wdata_i,
  input  logic                        shift_i,
  input  logic [desa_pkg::AddrW-1:0]  prev_i,
  output logic [desa_pkg::AddrW-1:0]  value_o
);
  logic [desa_pkg::AddrW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (we_i) begin
      val_d = wdata_i;
    end else if (shift_i) begin
      val_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;
endmodule

// File: rtl/desa_chain.sv
// Chain of head cells for one side; rotates its entries one place per cycle while rot_i is high, for a search.
// Depends on desa_pkg and desa_cell.
module desa_chain #(
  parameter int unsigned Depth = desa_pkg::DefSideDepth,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IdxW-1:0]            widx_i,
  input  logic [desa_pkg::AddrW-1:0] wdata_i,
  input  logic                       rot_i,
  input  logic [IdxW-1:0]            ridx_i,
  output logic [desa_pkg::AddrW-1:0] rdata_o,
  output logic [desa_pkg::AddrW-1:0] head0_o
);
  logic [desa_pkg::AddrW-1:0] val [Depth];

  // Rotation moves every entry one cell toward index 0, so cell 0 sees each entry in turn.
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    desa_cell u_cell (
      .clk_i  (clk_i),
      .we_i   (we_i && !rot_i && (widx_i == IdxW'(k))),
      .wdata_i(wdata_i),
      .shift_i(rot_i),
      .prev_i (val[(k + 1) % Depth]),
      .value_o(val[k])
    );
  end

  assign rdata_o = val[ridx_i];
  assign head0_o = val[0];
endmodule

// File: rtl/double_ended_stack_allocator.sv
// Double-ended stack allocator. Alloc, realloc, push, pop and unknown actions pass
// through two head fetch steps, one execute step and one result load after acceptance.
// Free adds a full rotation of the left chain, then of the right chain, before the result load.
// One item at a time: the next is accepted only in the idle state that follows the result
// load, and a receiver that still holds the previous result keeps the sequencer in the result load.
// rst_ni clears control state and pool registers; heads load from the reset pool at once.
module double_ended_stack_allocator #(
  parameter int unsigned SIDE_DEPTH       = desa_pkg::DefSideDepth,
  parameter int unsigned SNAP_DEPTH       = desa_pkg::DefSnapDepth,
  parameter int unsigned SNAP_BLOCK_BYTES = desa_pkg::DefSnapBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  desa_if.sink                          req_i,
  desa_if.source                        rsp_o,
  input  logic                          cfg_we_i,
  input  logic [desa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [desa_pkg::AddrW-1:0]    cfg_data_i
);
  localparam int unsigned IdxW  = $clog2(SIDE_DEPTH);
  localparam int unsigned CntW  = $clog2(SIDE_DEPTH + 1);
  localparam int unsigned SIdxW = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;
  localparam int unsigned STopW = $clog2(SNAP_DEPTH + 1);
  localparam int unsigned AW    = desa_pkg::AddrW;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SFetch  = 7'b0000010,
    SFetch2 = 7'b0000100,
    SExec   = 7'b0001000,
    SLeft   = 7'b0010000,
    SRight  = 7'b0100000,
    SOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] start_q, end_q;
  logic [AW-1:0] free_q, free_d;
  logic [CntW-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [STopW-1:0] stop_q, stop_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic found_q, found_d;
  desa_pkg::req_t req_q;
  desa_pkg::rsp_t rsp_q, rsp_d;
  desa_pkg::rsp_t wk_q, wk_d;
  logic rsp_valid_q, rsp_valid_d;

  // Heads fetched into registers before the execute step; they stay fixed during a
  // search rotation. rprev_q holds the right entry seen at position 0 in the previous cycle.
  logic [AW-1:0] ltop_q, lsec_q, rtop_q, rprev_q;

  // Pool bounds from the registers; re-init on any register write or reset.
  logic [AW:0] lo_w, hi_w;
  logic [AW-1:0] init_free;
  logic init_q;
  always_comb begin
    lo_w = {1'b0, start_q} + (AW+1)'(15);
    lo_w[3:0] = 4'd0;
    lo_w = lo_w + (AW+1)'(desa_pkg::HdrBytes);
    hi_w = {1'b0, end_q[AW-1:4], 4'd0};
    init_free = (hi_w >= lo_w + (AW+1)'(desa_pkg::HdrBytes))
              ? AW'(hi_w - (AW+1)'(desa_pkg::HdrBytes) - lo_w) : '0;
  end

  // Chains of head cells.
  logic l_we, r_we, l_rot, r_rot;
  logic [IdxW-1:0] l_widx, r_widx, l_ridx, r_ridx;
  logic [AW-1:0] l_wdata, r_wdata, l_rd, r_rd, l_h0, r_h0;

  desa_chain #(.Depth(SIDE_DEPTH)) u_left (
    .clk_i(clk_i), .we_i(l_we), .widx_i(l_widx), .wdata_i(l_wdata), .rot_i(l_rot),
    .ridx_i(l_ridx), .rdata_o(l_rd), .head0_o(l_h0)
  );
  desa_chain #(.Depth(SIDE_DEPTH)) u_right (
    .clk_i(clk_i), .we_i(r_we), .widx_i(r_widx), .wdata_i(r_wdata), .rot_i(r_rot),
    .ridx_i(r_ridx), .rdata_o(r_rd), .head0_o(r_h0)
  );

  // Snapshot stores: small flop arrays read at the top entry only.
  logic [AW-1:0] sn_free [SNAP_DEPTH];
  logic [AW-1:0] sn_left [SNAP_DEPTH];
  logic [AW-1:0] sn_right [SNAP_DEPTH];
  logic [CntW-1:0] sn_lc [SNAP_DEPTH];
  logic [CntW-1:0] sn_rc [SNAP_DEPTH];
  logic sn_we;
  logic [SIdxW-1:0] sn_widx, sn_ridx;
  logic [AW-1:0] sn_wf, sn_wl, sn_wr;

  always_ff @(posedge clk_i) begin
    if (sn_we) begin
      sn_free[sn_widx]  <= sn_wf;
      sn_left[sn_widx]  <= sn_wl;
      sn_right[sn_widx] <= sn_wr;
      sn_lc[sn_widx]    <= lcnt_q;
      sn_rc[sn_widx]    <= rcnt_q;
    end
  end

  // Read ports: the first fetch cycle reads the top of each side, the second reads the
  // entry below the left top, which is the header of the newest left block.
  assign l_ridx = (state_q == SFetch2) ? IdxW'(lcnt_q - CntW'(2)) : IdxW'(lcnt_q - CntW'(1));
  assign r_ridx = IdxW'(rcnt_q - CntW'(1));
  assign sn_widx = SIdxW'(stop_q);
  assign sn_ridx = SIdxW'(stop_q - STopW'(1));

  // Datapath for the execute step. During a free, the chains rotate and position 0
  // of each chain holds entry (scan_q) of the original order.
  logic [AW:0] cost;
  logic [AW-1:0] lhead, laddr_cmp;
  logic [AW:0] free_ext;

  always_comb begin
    state_d = state_q;
    free_d = free_q;
    lcnt_d = lcnt_q;
    rcnt_d = rcnt_q;
    stop_d = stop_q;
    scan_d = scan_q;
    found_d = found_q;
    rsp_d = rsp_q;
    wk_d = wk_q;
    rsp_valid_d = rsp_valid_q;
    l_we = 1'b0; r_we = 1'b0; l_rot = 1'b0; r_rot = 1'b0;
    l_widx = IdxW'(lcnt_q); r_widx = IdxW'(rcnt_q);
    l_wdata = '0; r_wdata = '0;
    sn_we = 1'b0; sn_wf = free_q; sn_wl = '0; sn_wr = '0;
    cost = desa_pkg::cost_of(req_q.req_size);
    lhead = '0; laddr_cmp = '0; free_ext = '0;

    if (rsp_o.ready && rsp_valid_q) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (req_i.valid && req_i.ready) begin
          state_d = SFetch;
        end
      end
      SFetch: begin
        state_d = SFetch2;
      end
      SFetch2: begin
        state_d = SExec;
      end
      SExec: begin
        wk_d.result_addr = '0;
        wk_d.status = desa_pkg::StOk;
        wk_d.free_bytes = '0;
        state_d = SOut;
        unique case (req_q.action)
          desa_pkg::ActAlloc, desa_pkg::ActRealloc, desa_pkg::ActPush: begin
            free_ext = {1'b0, free_q};
            lhead = ltop_q;
            if (req_q.action == desa_pkg::ActRealloc) begin
              laddr_cmp = lsec_q + AW'(desa_pkg::HdrBytes);
              if (lcnt_q < CntW'(2) || laddr_cmp != req_q.block_addr) begin
                wk_d.status = desa_pkg::StNotNewest;
              end else begin
                // Realloc first releases the newest left block; its header becomes
                // the new head, and the block stays released if the take fails.
                lcnt_d = lcnt_q - CntW'(1);
                free_d = free_q + (ltop_q - lsec_q);
                free_ext = {1'b0, free_d};
                lhead = lsec_q;
              end
            end
            if (req_q.action == desa_pkg::ActPush) begin
              cost = (AW+1)'(SNAP_BLOCK_BYTES);
              if (stop_q >= STopW'(SNAP_DEPTH)) begin
                wk_d.status = desa_pkg::StFull;
              end
            end
            if (wk_d.status == desa_pkg::StOk) begin
              if ((req_q.side && req_q.action == desa_pkg::ActAlloc)
                  ? (rcnt_q >= CntW'(SIDE_DEPTH)) : (lcnt_d >= CntW'(SIDE_DEPTH))) begin
                wk_d.status = desa_pkg::StFull;
              end else if (cost > free_ext) begin
                wk_d.status = desa_pkg::StNoSpace;
              end else begin
                free_d = AW'(free_ext - cost);
                if (req_q.side && req_q.action == desa_pkg::ActAlloc) begin
                  r_we = 1'b1;
                  r_widx = IdxW'(rcnt_q);
                  r_wdata = rtop_q - AW'(cost);
                  rcnt_d = rcnt_q + CntW'(1);
                  wk_d.result_addr = r_wdata + AW'(desa_pkg::HdrBytes);
                end else begin
                  l_we = 1'b1;
                  l_widx = IdxW'(lcnt_d);
                  l_wdata = lhead + AW'(cost);
                  lcnt_d = lcnt_d + CntW'(1);
                  wk_d.result_addr = lhead + AW'(desa_pkg::HdrBytes);
                  if (req_q.action == desa_pkg::ActPush) begin
                    sn_we = 1'b1;
                    sn_wf = free_q;
                    sn_wl = lhead;
                    sn_wr = rtop_q;
                    stop_d = stop_q + STopW'(1);
                  end
                end
              end
            end
          end
          desa_pkg::ActFree: begin
            scan_d = '0;
            found_d = 1'b0;
            state_d = SLeft;
          end
          desa_pkg::ActPop: begin
            if (stop_q == '0) begin
              wk_d.status = desa_pkg::StNoSnap;
            end else begin
              stop_d = stop_q - STopW'(1);
              free_d = sn_free[sn_ridx];
              lcnt_d = (sn_lc[sn_ridx] == '0 || sn_lc[sn_ridx] > CntW'(SIDE_DEPTH))
                     ? CntW'(1) : sn_lc[sn_ridx];
              rcnt_d = (sn_rc[sn_ridx] == '0 || sn_rc[sn_ridx] > CntW'(SIDE_DEPTH))
                     ? CntW'(1) : sn_rc[sn_ridx];
              l_we = 1'b1; l_widx = IdxW'(lcnt_d - CntW'(1)); l_wdata = sn_left[sn_ridx];
              r_we = 1'b1; r_widx = IdxW'(rcnt_d - CntW'(1)); r_wdata = sn_right[sn_ridx];
            end
          end
          default: ;
        endcase
        if (wk_d.status != desa_pkg::StOk) begin
          wk_d.result_addr = '0;
        end
      end
      SLeft: begin
        // Full rotation of the left chain; cell 0 holds entry scan_q.
        l_rot = 1'b1;
        if (!found_q && (CntW'(scan_q) + CntW'(1) < lcnt_q)
            && (l_h0 + AW'(desa_pkg::HdrBytes) == req_q.block_addr)) begin
          found_d = 1'b1;
          free_d = free_q + (ltop_q - l_h0);
          lcnt_d = CntW'(scan_q) + CntW'(1);
        end
        scan_d = scan_q + IdxW'(1);
        if (scan_q == IdxW'(SIDE_DEPTH - 1)) begin
          scan_d = '0;
          state_d = SRight;
        end
      end
      SRight: begin
        // Right chain rotation; the previous entry comes from a one-entry delay.
        r_rot = 1'b1;
        if (!found_q && scan_q != '0 && (CntW'(scan_q) < rcnt_q)
            && (r_h0 + AW'(desa_pkg::HdrBytes) == req_q.block_addr)) begin
          found_d = 1'b1;
          free_d = free_q + (rprev_q - rtop_q);
          rcnt_d = CntW'(scan_q);
        end
        scan_d = scan_q + IdxW'(1);
        if (scan_q == IdxW'(SIDE_DEPTH - 1)) begin
          state_d = SOut;
          wk_d.result_addr = '0;
          wk_d.status = found_d ? desa_pkg::StOk : desa_pkg::StUnknown;
        end
      end
      SOut: begin
        // The result register loads only once the previous item has left it.
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d = wk_q;
          rsp_d.free_bytes = free_q;
          rsp_valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    if (init_q) begin
      free_d = init_free;
      lcnt_d = CntW'(1);
      rcnt_d = CntW'(1);
      stop_d = '0;
      l_we = 1'b1; l_rot = 1'b0; l_widx = '0; l_wdata = AW'(lo_w - (AW+1)'(desa_pkg::HdrBytes));
      r_we = 1'b1; r_rot = 1'b0; r_widx = '0; r_wdata = AW'(hi_w - (AW+1)'(desa_pkg::HdrBytes));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SFetch) begin
      ltop_q <= l_rd;
      rtop_q <= r_rd;
    end
    if (state_q == SFetch2) begin
      lsec_q <= l_rd;
    end
    rprev_q <= r_h0;
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    wk_q <= wk_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      start_q <= '0;
      end_q <= '0;
      free_q <= '0;
      lcnt_q <= CntW'(1);
      rcnt_q <= CntW'(1);
      stop_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      init_q <= 1'b1;
    end else begin
      state_q <= state_d;
      free_q <= free_d;
      lcnt_q <= lcnt_d;
      rcnt_q <= rcnt_d;
      stop_q <= stop_d;
      scan_q <= scan_d;
      found_q <= found_d;
      rsp_valid_q <= rsp_valid_d;
      init_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (desa_pkg::reg_idx_e'(cfg_idx_i))
          desa_pkg::RegPoolStart: start_q <= cfg_data_i;
          desa_pkg::RegPoolEnd:   end_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign req_i.ready = (state_q == SIdle) && !init_q && !cfg_we_i;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data = rsp_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q >= CntW'(1) && lcnt_q <= CntW'(SIDE_DEPTH)) else $error("left count out of range");
  a_snap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q <= STopW'(SNAP_DEPTH)) else $error("snapshot top out of range");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q == SFetch) else $error("item not taken up");
endmodule

// File: test/tb_double_ended_stack_allocator.sv
// Self-checking testbench for double_ended_stack_allocator.
// Depends on desa_pkg, desa_if and the allocator top level.
`timescale 1ns / 1ps

module tb_double_ended_stack_allocator;

  localparam int unsigned SideDepth = desa_pkg::DefSideDepth;
  localparam int unsigned SnapDepth = desa_pkg::DefSnapDepth;
  localparam int unsigned SnapBytes = desa_pkg::DefSnapBytes;
  localparam int unsigned AddrW = desa_pkg::AddrW;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned NumPhases = 9;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ResetRows = 8;
  localparam int unsigned DirRows = 22;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [desa_pkg::CfgIdxW-1:0] cfg_idx;
  logic [AddrW-1:0] cfg_data;

  desa_if #(.T(desa_pkg::req_t)) req_if ();
  desa_if #(.T(desa_pkg::rsp_t)) rsp_if ();

  double_ended_stack_allocator dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // One row of the directed table. When check_typed is set, the expected item is
  // the one typed into the row; the model of the pool is still advanced.
  typedef struct packed {
    logic [desa_pkg::ActW-1:0] action;
    logic [AddrW-1:0]          req_size;
    logic                      side;
    logic [AddrW-1:0]          block_addr;
    logic                      check_typed;
    desa_pkg::rsp_t            want;
  } dir_row_t;

  // The first rows run on the reset pool (start 0, end 0), which is an invalid
  // region with no free space. The rest run on a 4 KiB pool at 0x1000.
  localparam dir_row_t DirTable [DirRows] = '{
    '{desa_pkg::ActAlloc,   32'd0,         1'b0, 32'd0,         1'b1,
      '{32'd0, desa_pkg::StNoSpace, 32'd0}},
    '{desa_pkg::ActAlloc,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, desa_pkg::StNoSpace, 32'd0}},
    '{desa_pkg::ActFree,    32'd0,         1'b0, 32'd0,         1'b1,
      '{32'd0, desa_pkg::StUnknown, 32'd0}},
    '{desa_pkg::ActFree,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, desa_pkg::StUnknown, 32'd0}},
    '{desa_pkg::ActRealloc, 32'd16,        1'b0, 32'h10,        1'b1,
      '{32'd0, desa_pkg::StNotNewest, 32'd0}},
    '{desa_pkg::ActPush,    32'd0,         1'b0, 32'd0,         1'b1,
      '{32'd0, desa_pkg::StNoSpace, 32'd0}},
    '{desa_pkg::ActPop,     32'd0,         1'b0, 32'd0,         1'b1,
      '{32'd0, desa_pkg::StNoSnap, 32'd0}},
    '{3'd7,                 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActAlloc,   32'd0,         1'b0, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActAlloc,   32'd100,       1'b1, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActAlloc,   32'hFFFF_FFFF, 1'b0, 32'd0,         1'b1,
      '{32'd0, desa_pkg::StNoSpace, 32'hF50}},
    '{desa_pkg::ActPush,    32'd0,         1'b0, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActAlloc,   32'd40,        1'b0, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActRealloc, 32'd200,       1'b0, 32'h1040,      1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActRealloc, 32'd8,         1'b0, 32'h1010,      1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActPop,     32'd0,         1'b0, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActFree,    32'd0,         1'b0, 32'h1010,      1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActFree,    32'd0,         1'b1, 32'h1F80,      1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActFree,    32'd0,         1'b0, 32'h1234,      1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActAlloc,   32'd17,        1'b1, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{3'd5,                 32'd15,        1'b0, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}},
    '{desa_pkg::ActPop,     32'd0,         1'b1, 32'd0,         1'b0,
      '{32'd0, desa_pkg::StOk, 32'd0}}
  };

  // Model of the pool. Heads and counts follow the block's own bookkeeping so
  // that addresses of live blocks can be picked for free and realloc.
  logic [AddrW-1:0] pool_lo_reg, pool_hi_reg;
  logic [AddrW-1:0] pool_free;
  logic [AddrW-1:0] left_head [SideDepth];
  logic [AddrW-1:0] right_head [SideDepth];
  int unsigned      left_num, right_num;
  logic [AddrW-1:0] saved_free [SnapDepth];
  logic [AddrW-1:0] saved_left [SnapDepth];
  logic [AddrW-1:0] saved_right [SnapDepth];
  int unsigned      saved_lnum [SnapDepth];
  int unsigned      saved_rnum [SnapDepth];
  int unsigned      snap_level;

  desa_pkg::rsp_t pending_rsp [$];
  int unsigned    err_count;
  int unsigned    stall_cycles;
  int unsigned    send_idle_pct, recv_idle_pct;

  // Re-initializes the heads from the two pool registers, without wrap.
  function automatic void pool_reinit();
    logic [63:0] lo, hi;
    lo = ((64'(pool_lo_reg) + 64'd15) & ~64'hF) + 64'd16;
    hi = 64'(pool_hi_reg & ~32'hF);
    left_head[0]  = 32'(lo - 64'd16);
    right_head[0] = 32'(hi - 64'd16);
    left_num   = 1;
    right_num  = 1;
    snap_level = 0;
    pool_free  = (hi >= lo + 64'd16) ? 32'(hi - 64'd16 - lo) : 32'd0;
  endfunction

  function automatic logic [63:0] block_cost(input logic [AddrW-1:0] size);
    return ((64'(size) + 64'd15) & ~64'hF) + 64'd16;
  endfunction

  // Carves a block of the given cost from one side.
  function automatic desa_pkg::status_e carve(input logic side, input logic [63:0] cost,
                                              output logic [AddrW-1:0] addr);
    logic [AddrW-1:0] h;
    addr = '0;
    if ((side ? right_num : left_num) >= SideDepth) return desa_pkg::StFull;
    if (cost > 64'(pool_free)) return desa_pkg::StNoSpace;
    pool_free = pool_free - 32'(cost);
    if (!side) begin
      h = left_head[left_num-1];
      addr = h + 32'd16;
      left_head[left_num] = h + 32'(cost);
      left_num++;
    end else begin
      h = right_head[right_num-1] - 32'(cost);
      right_head[right_num] = h;
      right_num++;
      addr = h + 32'd16;
    end
    return desa_pkg::StOk;
  endfunction

  // Releases a block and every newer one on its side; left side searched first.
  function automatic desa_pkg::status_e release_block(input logic [AddrW-1:0] addr);
    for (int unsigned i = 0; i + 1 < left_num; i++) begin
      if (left_head[i] + 32'd16 == addr) begin
        pool_free = pool_free + (left_head[left_num-1] - left_head[i]);
        left_num = i + 1;
        return desa_pkg::StOk;
      end
    end
    for (int unsigned i = 1; i < right_num; i++) begin
      if (right_head[i] + 32'd16 == addr) begin
        pool_free = pool_free + (right_head[i-1] - right_head[right_num-1]);
        right_num = i;
        return desa_pkg::StOk;
      end
    end
    return desa_pkg::StUnknown;
  endfunction

  // Works out the response to one accepted request and advances the model.
  function automatic desa_pkg::rsp_t predict_alloc(input desa_pkg::req_t rq);
    logic [AddrW-1:0]  addr, f, lh, rh;
    int unsigned       ln, rn;
    desa_pkg::status_e st;
    desa_pkg::rsp_t    r;
    addr = '0;
    st = desa_pkg::StOk;
    unique case (rq.action)
      desa_pkg::ActAlloc: st = carve(rq.side, block_cost(rq.req_size), addr);
      desa_pkg::ActFree: st = release_block(rq.block_addr);
      desa_pkg::ActRealloc: begin
        if (left_num >= 2 && left_head[left_num-2] + 32'd16 == rq.block_addr) begin
          pool_free = pool_free + (left_head[left_num-1] - left_head[left_num-2]);
          left_num--;
          st = carve(1'b0, block_cost(rq.req_size), addr);
        end else begin
          st = desa_pkg::StNotNewest;
        end
      end
      desa_pkg::ActPush: begin
        if (snap_level >= SnapDepth) begin
          st = desa_pkg::StFull;
        end else begin
          f  = pool_free;
          lh = left_head[left_num-1];
          rh = right_head[right_num-1];
          ln = left_num;
          rn = right_num;
          st = carve(1'b0, 64'(SnapBytes), addr);
          if (st == desa_pkg::StOk) begin
            saved_free[snap_level]  = f;
            saved_left[snap_level]  = lh;
            saved_right[snap_level] = rh;
            saved_lnum[snap_level]  = ln;
            saved_rnum[snap_level]  = rn;
            snap_level++;
          end
        end
      end
      desa_pkg::ActPop: begin
        if (snap_level == 0) begin
          st = desa_pkg::StNoSnap;
        end else begin
          snap_level--;
          pool_free = saved_free[snap_level];
          left_num  = saved_lnum[snap_level];
          right_num = saved_rnum[snap_level];
          left_head[left_num-1]   = saved_left[snap_level];
          right_head[right_num-1] = saved_right[snap_level];
        end
      end
      default: ;
    endcase
    if (st != desa_pkg::StOk) addr = '0;
    r.result_addr = addr;
    r.status      = st;
    r.free_bytes  = pool_free;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Response side: random back-pressure, checking against the oldest expected
  // item, and a watchdog on cycles in which neither channel moves an item.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected item %h", $time, rsp_if.data);
          err_count++;
        end else begin
          if (rsp_if.data.result_addr !== pending_rsp[0].result_addr) begin
            $display("%0t: result_addr expected %h actual %h", $time,
                     pending_rsp[0].result_addr, rsp_if.data.result_addr);
            err_count++;
          end
          if (rsp_if.data.status !== pending_rsp[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     pending_rsp[0].status, rsp_if.data.status);
            err_count++;
          end
          if (rsp_if.data.free_bytes !== pending_rsp[0].free_bytes) begin
            $display("%0t: free_bytes expected %h actual %h", $time,
                     pending_rsp[0].free_bytes, rsp_if.data.free_bytes);
            err_count++;
          end
          void'(pending_rsp.pop_front());
        end
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Presents one request, holds it until it is accepted, queues the expected
  // response, then idles at random. Valid is left high when no gap follows.
  task automatic send_request(input desa_pkg::req_t rq, input logic use_typed,
                              input desa_pkg::rsp_t typed);
    desa_pkg::rsp_t r;
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    r = predict_alloc(rq);
    pending_rsp.push_back(use_typed ? typed : r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Writes one pool register once the block has drained.
  task automatic write_reg(input desa_pkg::reg_idx_e idx, input logic [AddrW-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == desa_pkg::RegPoolStart) pool_lo_reg = value;
    else pool_hi_reg = value;
    pool_reinit();
  endtask

  // Builds a random request from the model, mostly aimed at live blocks.
  // In fill phases allocs and pushes dominate and frees are rare, so the side stacks and
  // the snapshot stack reach their limits.
  function automatic desa_pkg::req_t random_request(input bit fill);
    desa_pkg::req_t rq;
    int unsigned r, i;
    rq.action     = desa_pkg::ActAlloc;
    rq.req_size   = $urandom();
    rq.side       = 1'($urandom_range(1));
    rq.block_addr = $urandom();
    r = $urandom_range(99);
    if (r < 8) rq.req_size = $urandom_range(4096);
    else if (r < 85) rq.req_size = $urandom_range(96);
    r = $urandom_range(99);
    if (fill) begin
      if (r < 55) rq.action = desa_pkg::ActAlloc;
      else if (r < 58) rq.action = desa_pkg::ActFree;
      else if (r < 63) rq.action = desa_pkg::ActRealloc;
      else if (r < 88) rq.action = desa_pkg::ActPush;
      else if (r < 97) rq.action = desa_pkg::ActPop;
      else rq.action = 3'($urandom_range(5, 7));
    end else begin
      if (r < 40) rq.action = desa_pkg::ActAlloc;
      else if (r < 58) rq.action = desa_pkg::ActFree;
      else if (r < 70) rq.action = desa_pkg::ActRealloc;
      else if (r < 82) rq.action = desa_pkg::ActPush;
      else if (r < 94) rq.action = desa_pkg::ActPop;
      else rq.action = 3'($urandom_range(5, 7));
    end
    if (rq.action == desa_pkg::ActFree && $urandom_range(99) < 85) begin
      if (left_num > 1 && (right_num < 2 || $urandom_range(1) == 0)) begin
        i = $urandom_range(left_num - 2);
        rq.block_addr = left_head[i] + 32'd16;
      end else if (right_num > 1) begin
        i = $urandom_range(right_num - 1, 1);
        rq.block_addr = right_head[i] + 32'd16;
      end
    end
    if (rq.action == desa_pkg::ActRealloc && left_num >= 2 && $urandom_range(99) < 80) begin
      rq.block_addr = left_head[left_num-2] + 32'd16;
    end
    return rq;
  endfunction

  initial begin
    desa_pkg::req_t rq;
    logic [31:0]    st_val, en_val;
    desa_pkg::rsp_t none;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = desa_pkg::RegPoolStart;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    err_count = 0;
    send_idle_pct = 31;
    recv_idle_pct = 88;
    none = '0;
    pool_lo_reg = '0;
    pool_hi_reg = '0;
    for (int unsigned k = 0; k < SideDepth; k++) begin
      left_head[k]  = '0;
      right_head[k] = '0;
    end
    pool_reinit();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the reset pool first, then a known 4 KiB pool.
    for (int unsigned k = 0; k < DirRows; k++) begin
      if (k == ResetRows) begin
        write_reg(desa_pkg::RegPoolStart, 32'h1000);
        write_reg(desa_pkg::RegPoolEnd, 32'h2000);
      end
      rq.action     = DirTable[k].action;
      rq.req_size   = DirTable[k].req_size;
      rq.side       = DirTable[k].side;
      rq.block_addr = DirTable[k].block_addr;
      send_request(rq, DirTable[k].check_typed, DirTable[k].want);
    end

    // Random part: each idling mode runs over three pool settings.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      send_idle_pct = (p < 3) ? 31 : (p < 6) ? 88 : 0;
      recv_idle_pct = (p < 3) ? 88 : (p < 6) ? 31 : 0;
      case (p % 3)
        0: begin
          st_val = $urandom();
          en_val = st_val + $urandom_range(2048);
          if (p == 6) begin
            st_val = 32'hFFFF_FFFF;
            en_val = 32'hFFFF_FFFF;
          end
        end
        1: begin
          st_val = (p == 1) ? 32'd0 : $urandom_range(64);
          en_val = 32'hFFFF_FFFF;
        end
        default: begin
          st_val = $urandom_range(32'h0FFF_FFFF) & ~32'h3;
          en_val = st_val + $urandom_range(12000);
          if (p == 8) en_val = st_val - $urandom_range(40);
        end
      endcase
      write_reg(desa_pkg::RegPoolEnd, en_val);
      write_reg(desa_pkg::RegPoolStart, st_val);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_request(random_request(p % 3 == 1), 1'b0, none);
      end
    end

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
